// ----- hw/rtl/rtcc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtcc_pkg: shared types and constants of the calendar counter
// Command codes, field widths, the calendar state record and the month
// length lookup.
// ----------------------------------------------------------------------------
package rtcc_pkg;

  // command codes carried in tuser
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_SET_TIME = 2'd1;
  localparam logic [1:0] CMD_SET_DATE = 2'd2;

  // field widths
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int WDAY_W  = 3;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 16;
  localparam int CMD_W   = 2;

  localparam int FIELDS_W = SEC_W + MIN_W + HOUR_W + WDAY_W + DAY_W + MONTH_W + YEAR_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W    = TDATA_W - FIELDS_W;

  // counter tops
  localparam logic [SEC_W-1:0]   SEC_TOP   = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_TOP   = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_TOP  = 5'd23;
  localparam logic [WDAY_W-1:0]  WDAY_TOP  = 3'd6;
  localparam logic [MONTH_W-1:0] MONTH_TOP = 4'd11;
  localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd1;

  // time and date record, packed lowest field last so it matches tdata order
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  weekday;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minutes;
    logic [SEC_W-1:0]   seconds;
  } cal_t;

  // reset value: 16:26:12, Saturday 16 September 2023
  localparam cal_t CAL_RESET = '{
    year:    16'd2023,
    month:   4'd8,
    day:     5'd16,
    weekday: 3'd5,
    hour:    5'd16,
    minutes: 6'd26,
    seconds: 6'd12
  };

  // month length, February 29 days when the year is a multiple of four
  function automatic logic [DAY_W-1:0] days_in_month(
    input logic [MONTH_W-1:0] month,
    input logic [YEAR_W-1:0]  year
  );
    logic [DAY_W-1:0] len;
    unique case (month)
      FEBRUARY: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd3:     len = 5'd30;
      4'd5:     len = 5'd30;
      4'd8:     len = 5'd30;
      4'd10:    len = 5'd30;
      default:  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/rtcc_advance.sv -----
// ----------------------------------------------------------------------------
// rtcc_advance: next calendar state
// Applies one command word to the current state: one-second tick with the
// carry cascade into the date, a load of the time or date fields, or no change.
// ----------------------------------------------------------------------------
module rtcc_advance (
  input  rtcc_pkg::cal_t           cur,
  input  logic [rtcc_pkg::CMD_W-1:0] cmd,
  input  rtcc_pkg::cal_t           load,
  output rtcc_pkg::cal_t           nxt
);

  logic                          sec_wrap;
  logic                          min_wrap;
  logic                          hour_wrap;
  logic                          day_wrap;
  logic [rtcc_pkg::DAY_W-1:0]    month_len;
  rtcc_pkg::cal_t                ticked;

  // wrap flags of the cascade
  assign sec_wrap  = (cur.seconds >= rtcc_pkg::SEC_TOP);
  assign min_wrap  = (cur.minutes >= rtcc_pkg::MIN_TOP);
  assign hour_wrap = (cur.hour >= rtcc_pkg::HOUR_TOP);
  assign month_len = rtcc_pkg::days_in_month(cur.month, cur.year);
  assign day_wrap  = (cur.day >= month_len);

  // one-second tick
  always_comb begin
    ticked = cur;
    if (!sec_wrap) begin
      ticked.seconds = cur.seconds + 1'b1;
    end else begin
      ticked.seconds = '0;
      if (!min_wrap) begin
        ticked.minutes = cur.minutes + 1'b1;
      end else begin
        ticked.minutes = '0;
        if (!hour_wrap) begin
          ticked.hour = cur.hour + 1'b1;
        end else begin
          // midnight: weekday and date advance
          ticked.hour    = '0;
          ticked.weekday = (cur.weekday >= rtcc_pkg::WDAY_TOP) ? '0 : cur.weekday + 1'b1;
          if (!day_wrap) begin
            ticked.day = cur.day + 1'b1;
          end else begin
            ticked.day = {{(rtcc_pkg::DAY_W-1){1'b0}}, 1'b1};
            if (cur.month >= rtcc_pkg::MONTH_TOP) begin
              ticked.month = '0;
              ticked.year  = cur.year + 1'b1;
            end else begin
              ticked.month = cur.month + 1'b1;
            end
          end
        end
      end
    end
  end

  // command select
  always_comb begin
    nxt = cur;
    unique case (cmd)
      rtcc_pkg::CMD_TICK: begin
        nxt = ticked;
      end
      rtcc_pkg::CMD_SET_TIME: begin
        nxt.seconds = load.seconds;
        nxt.minutes = load.minutes;
        nxt.hour    = load.hour;
      end
      rtcc_pkg::CMD_SET_DATE: begin
        nxt.weekday = load.weekday;
        nxt.day     = load.day;
        nxt.month   = load.month;
        nxt.year    = load.year;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ----- hw/rtl/rtcc_out_reg.sv -----
// ----------------------------------------------------------------------------
// rtcc_out_reg: result register
// Holds one result word on the master side until it is taken; a new word
// may load in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module rtcc_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  rtcc_pkg::cal_t                result,
  output logic                          room,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rtcc_pkg::TDATA_W-1:0]  m_tdata
);

  logic           valid;
  rtcc_pkg::cal_t data;

  // room when empty or the held word leaves this cycle
  assign room = !valid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = {{rtcc_pkg::PAD_W{1'b0}}, data};

endmodule

// ----- hw/rtl/rtc_calendar_counter_unit.sv -----
// ----------------------------------------------------------------------------
// rtc_calendar_counter_unit: real-time clock and calendar counter
// Keeps time of day and date, advanced by tick words, loaded by set words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one command word per cycle while s_tready is high:
//   tuser is the command (tick one second, load time, load date, code 3
//   does nothing) and tdata the load fields. Every accepted word yields
//   exactly one result word on the master side with the full time and
//   date after the command. The result is in the output register the cycle
//   after the word is accepted. One word per cycle passes while the
//   receiver is ready; the single output register refills in the cycle
//   it drains. The calendar registers update at accept, so each result
//   already reflects all earlier words.
//   Reset empties the output register and sets the calendar to 16:26:12,
//   Saturday 16 September 2023.
//   When the receiver stalls with a result held, s_tready falls and the
//   calendar holds until the result is taken.
// ----------------------------------------------------------------------------
module rtc_calendar_counter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // fields from bit 0: new_seconds, new_minutes, new_hour, new_weekday,
  // new_day_of_month, new_month, new_year, zero fill
  input  logic [rtcc_pkg::TDATA_W-1:0]  s_tdata,
  // fields from bit 0: command
  input  logic [rtcc_pkg::CMD_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // fields from bit 0: cur_seconds, cur_minutes, cur_hour, cur_weekday,
  // cur_day_of_month, cur_month, cur_year, zero fill
  output logic [rtcc_pkg::TDATA_W-1:0]  m_tdata
);

  rtcc_pkg::cal_t cal;
  rtcc_pkg::cal_t cal_next;
  rtcc_pkg::cal_t load_fields;
  logic           room;
  logic           accept;

  // load fields straight from the packed word
  assign load_fields = s_tdata[rtcc_pkg::FIELDS_W-1:0];

  assign s_tready = room;
  assign accept   = s_tvalid && room;

  // next state logic
  rtcc_advance u_advance (
    .cur  (cal),
    .cmd  (s_tuser),
    .load (load_fields),
    .nxt  (cal_next)
  );

  // calendar registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= rtcc_pkg::CAL_RESET;
    end else if (accept) begin
      cal <= cal_next;
    end
  end

  // result register
  rtcc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (cal_next),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- tb/rtc_calendar_counter_checker.sv -----
// ----------------------------------------------------------------------------
// rtc_calendar_counter_checker: calendar predictor and result scoreboard
// Watches both stream channels of the calendar counter, advances its own
// copy of the time and date for every accepted command word and compares
// each result word field by field with the oldest predicted calendar.
// ----------------------------------------------------------------------------
module rtc_calendar_counter_checker
  import rtcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  // fields from bit 0: new_seconds, new_minutes, new_hour, new_weekday,
  // new_day_of_month, new_month, new_year, zero fill
  input  logic [TDATA_W-1:0]  s_tdata,
  // fields from bit 0: command
  input  logic [CMD_W-1:0]    s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  // fields from bit 0: cur_seconds, cur_minutes, cur_hour, cur_weekday,
  // cur_day_of_month, cur_month, cur_year, zero fill
  input  logic [TDATA_W-1:0]  m_tdata,
  output int                  words_in,
  output int                  words_out,
  output int                  month_rolls,
  output int                  year_rolls,
  output int                  fail_count
);

  // months that are not 31 days long
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd5;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd8;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd10;

  // 16:26:12, Saturday 16 September 2023
  localparam cal_t POWER_ON = '{
    year:    16'd2023,
    month:   4'd8,
    day:     5'd16,
    weekday: 3'd5,
    hour:    5'd16,
    minutes: 6'd26,
    seconds: 6'd12
  };

  cal_t clock_now;
  cal_t calendar_q[$];

  // length of a month, leap February on every fourth year
  function automatic logic [DAY_W-1:0] month_length(
    input logic [MONTH_W-1:0] mon,
    input logic [YEAR_W-1:0]  yr
  );
    case (mon)
      MON_FEB: return (yr % 4 == 0) ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  // calendar after one command word
  function automatic cal_t next_calendar(
    input cal_t             cur,
    input logic [CMD_W-1:0] cmd,
    input cal_t             load
  );
    cal_t nxt;
    nxt = cur;
    case (cmd)
      CMD_TICK: begin
        // counters at or past their top wrap and carry
        if (cur.seconds < SEC_TOP) begin
          nxt.seconds = cur.seconds + 1'b1;
        end else begin
          nxt.seconds = '0;
          if (cur.minutes < MIN_TOP) begin
            nxt.minutes = cur.minutes + 1'b1;
          end else begin
            nxt.minutes = '0;
            if (cur.hour < HOUR_TOP) begin
              nxt.hour = cur.hour + 1'b1;
            end else begin
              // midnight: next weekday and next date
              nxt.hour    = '0;
              nxt.weekday = (cur.weekday >= WDAY_TOP) ? 3'd0 : cur.weekday + 1'b1;
              if (cur.day >= month_length(cur.month, cur.year)) begin
                nxt.day = 5'd1;
                if (cur.month >= MONTH_TOP) begin
                  nxt.month = '0;
                  nxt.year  = cur.year + 1'b1;
                end else begin
                  nxt.month = cur.month + 1'b1;
                end
              end else begin
                nxt.day = cur.day + 1'b1;
              end
            end
          end
        end
      end
      CMD_SET_TIME: begin
        nxt.seconds = load.seconds;
        nxt.minutes = load.minutes;
        nxt.hour    = load.hour;
      end
      CMD_SET_DATE: begin
        nxt.weekday = load.weekday;
        nxt.day     = load.day;
        nxt.month   = load.month;
        nxt.year    = load.year;
      end
      default: ;
    endcase
    return nxt;
  endfunction

  function automatic int field_differs(
    input string       name,
    input logic [15:0] want,
    input logic [15:0] got
  );
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // predict on the command side, compare on the result side
  always @(posedge clk) begin
    cal_t want;
    cal_t got;
    cal_t nxt;
    int   errs;
    errs = 0;
    if (rst) begin
      clock_now = POWER_ON;
      calendar_q.delete();
      words_in    <= 0;
      words_out   <= 0;
      month_rolls <= 0;
      year_rolls  <= 0;
      fail_count  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = cal_t'(m_tdata[FIELDS_W-1:0]);
        if (calendar_q.size() == 0) begin
          $error("result word %h with no calendar expected", m_tdata);
          errs++;
        end else begin
          want = calendar_q.pop_front();
          errs += field_differs("cur_seconds", 16'(want.seconds), 16'(got.seconds));
          errs += field_differs("cur_minutes", 16'(want.minutes), 16'(got.minutes));
          errs += field_differs("cur_hour", 16'(want.hour), 16'(got.hour));
          errs += field_differs("cur_weekday", 16'(want.weekday), 16'(got.weekday));
          errs += field_differs("cur_day_of_month", 16'(want.day), 16'(got.day));
          errs += field_differs("cur_month", 16'(want.month), 16'(got.month));
          errs += field_differs("cur_year", want.year, got.year);
        end
        words_out <= words_out + 1;
      end
      if (s_tvalid && s_tready) begin
        nxt = next_calendar(clock_now, s_tuser, cal_t'(s_tdata[FIELDS_W-1:0]));
        if (s_tuser == CMD_TICK && nxt.month != clock_now.month)
          month_rolls <= month_rolls + 1;
        if (s_tuser == CMD_TICK && nxt.year != clock_now.year)
          year_rolls <= year_rolls + 1;
        clock_now = nxt;
        calendar_q.push_back(nxt);
        words_in <= words_in + 1;
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ----- tb/rtc_calendar_counter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// rtc_calendar_counter_unit_tb: testbench of the calendar counter
// Drives tick, load-time, load-date and unused command words with random
// gaps and result stalls; the checker beside the block predicts every
// calendar word and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module rtc_calendar_counter_unit_tb;
  import rtcc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_IDLE = 2'd3;
  localparam int RANDOM_WORDS = 950;
  localparam int QUIET_FROM   = 400;
  localparam int QUIET_TO     = 600;
  localparam int DRAIN_AT     = 700;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;
  logic [CMD_W-1:0]   s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic               quiet;
  int                 words_in;
  int                 words_out;
  int                 month_rolls;
  int                 year_rolls;
  int                 fail_count;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  rtc_calendar_counter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rtc_calendar_counter_checker calendar_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .words_in    (words_in),
    .words_out   (words_out),
    .month_rolls (month_rolls),
    .year_rolls  (year_rolls),
    .fail_count  (fail_count)
  );

  // receiver stalls about 30 percent of cycles outside the quiet stretch
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 30);
  end

  // all load fields random, so ignored fields toggle too
  function automatic cal_t rand_fields();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return cal_t'(r[FIELDS_W-1:0]);
  endfunction

  function automatic cal_t time_of(
    input logic [HOUR_W-1:0] h,
    input logic [MIN_W-1:0]  m,
    input logic [SEC_W-1:0]  s
  );
    cal_t f;
    f = rand_fields();
    f.hour    = h;
    f.minutes = m;
    f.seconds = s;
    return f;
  endfunction

  function automatic cal_t date_of(
    input logic [WDAY_W-1:0]  wd,
    input logic [DAY_W-1:0]   d,
    input logic [MONTH_W-1:0] mo,
    input logic [YEAR_W-1:0]  y
  );
    cal_t f;
    f = rand_fields();
    f.weekday = wd;
    f.day     = d;
    f.month   = mo;
    f.year    = y;
    return f;
  endfunction

  // one command word, with a random gap ahead of it outside the quiet stretch
  task automatic send_word(input logic [CMD_W-1:0] cmd, input cal_t fields);
    if (!quiet) begin
      while ($urandom_range(99) < 30) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{PAD_W{1'b0}}, fields};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // load a date, go to the last second of that day and tick past midnight
  task automatic last_second(
    input logic [WDAY_W-1:0]  wd,
    input logic [DAY_W-1:0]   d,
    input logic [MONTH_W-1:0] mo,
    input logic [YEAR_W-1:0]  y
  );
    send_word(CMD_SET_DATE, date_of(wd, d, mo, y));
    send_word(CMD_SET_TIME, time_of(5'd23, 6'd59, 6'd59));
    send_word(CMD_TICK, rand_fields());
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (words_in != words_out);
  endtask

  initial begin
    int n;
    int pick;
    rst      = 1'b1;
    quiet    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_TICK;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_word(CMD_TICK, rand_fields());
    send_word(CMD_IDLE, rand_fields());
    last_second(3'd6, 5'd31, 4'd11, 16'd2023);    // new year, sunday wraps
    last_second(3'd1, 5'd28, 4'd1, 16'd2023);     // february, common year
    last_second(3'd2, 5'd28, 4'd1, 16'd2024);     // february 28, leap year
    last_second(3'd3, 5'd29, 4'd1, 16'd2024);     // february 29
    last_second(3'd4, 5'd31, 4'd11, 16'hFFFF);    // year counter wraps
    last_second(3'd7, 5'd0, 4'd15, 16'd0);        // weekday, day, month out of range
    last_second(3'd0, 5'd31, 4'd3, 16'd2024);     // day past a 30-day month
    send_word(CMD_SET_TIME, time_of(5'd31, 6'd63, 6'd63));
    send_word(CMD_TICK, rand_fields());
    drain();

    // random mix, biased toward midnight and month ends
    n = 0;
    while (n < RANDOM_WORDS) begin
      quiet <= (n >= QUIET_FROM && n < QUIET_TO);
      if (n >= DRAIN_AT && n < DRAIN_AT + 8) begin
        drain();
        n = DRAIN_AT + 8;
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat ($urandom_range(8, 1)) begin
          send_word(CMD_TICK, rand_fields());
          n++;
        end
      end else begin
        if (pick < 65)
          send_word(CMD_SET_TIME, time_of(5'd23, 6'd59, SEC_W'($urandom_range(59, 50))));
        else if (pick < 80)
          send_word(CMD_SET_DATE, date_of(WDAY_W'($urandom_range(6, 0)),
                                          DAY_W'($urandom_range(31, 26)),
                                          MONTH_W'($urandom_range(11, 0)),
                                          YEAR_W'($urandom)));
        else if (pick < 88)
          send_word(CMD_SET_TIME, time_of(HOUR_W'($urandom_range(23, 0)),
                                          MIN_W'($urandom_range(59, 0)),
                                          SEC_W'($urandom_range(59, 0))));
        else if (pick < 95)
          send_word(CMD_W'($urandom_range(3, 0)), rand_fields());
        else
          send_word(CMD_IDLE, rand_fields());
        n++;
      end
    end

    // let the last results come out
    s_tvalid <= 1'b0;
    quiet    <= 1'b0;
    do @(posedge clk); while (words_in != words_out);
    repeat (5) @(posedge clk);

    $display("%0d command words checked against the predicted calendar", words_out);
    $display("%0d month and %0d year rollovers, out-of-range loads included",
             month_rolls, year_rolls);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
